>>> design/triangle_tile_coverage_assert.svh
// ----------------------------------------------------------------------------
// triangle_tile_coverage_assert.svh
// Assertion macros shared by the tile coverage design.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TILE_COVERAGE_ASSERT_SVH
`define TRIANGLE_TILE_COVERAGE_ASSERT_SVH

// Check that cons holds in the same cycle whenever ante holds
`define TTC_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons follows ante after the delay dly
`define TTC_ASSERT_DELAY(label, clk, rstn, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

>>> design/ttc_pkg.sv
// ----------------------------------------------------------------------------
// ttc_pkg
// Types, widths and constants of the triangle tile coverage pipeline.
// ----------------------------------------------------------------------------
package ttc_pkg;

    // Tile edge length in pixels (2..8)
    localparam int TILE_SIZE  = 8;
    localparam int NUM_EDGES  = 3;

    localparam int COORD_W    = 13;
    localparam int CMP_W      = COORD_W + 1;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int OFS_W      = COORD_W + 2;
    localparam int PROD_W     = OFS_W + DIFF_W;
    localparam int EDGE_W     = PROD_W + 1;
    localparam int PIX_W      = 13;
    localparam int FB_W       = 13;
    localparam int TILE_W     = 9;
    localparam int COLOR_W    = 24;
    localparam int MASK_W     = 64;
    localparam int CFG_IDX_W  = 4;

    // Register stages from accept to result strobe
    localparam int PIPE_DEPTH = 6;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [CMP_W-1:0]   cmp_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [OFS_W-1:0]   ofs_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [EDGE_W-1:0]  edge_t;
    typedef logic [PIX_W-1:0]          pix_t;
    typedef logic [FB_W-1:0]           fb_t;
    typedef logic [TILE_W-1:0]         tile_t;
    typedef logic [COLOR_W-1:0]        color_t;
    typedef logic [MASK_W-1:0]         mask_t;
    typedef logic [TILE_SIZE-1:0]      line_t;
    typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

    // Register indexes
    localparam cfg_idx_t REG_FB_WIDTH  = cfg_idx_t'(0);
    localparam cfg_idx_t REG_FB_HEIGHT = cfg_idx_t'(1);

    localparam fb_t FB_WIDTH_RST  = fb_t'(800);
    localparam fb_t FB_HEIGHT_RST = fb_t'(480);

    // Triangle vertices
    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
        coord_t cx;
        coord_t cy;
    } tri_t;

    // Fields passed through unchanged
    typedef struct packed {
        color_t color;
        tile_t  tile_col;
        tile_t  tile_row;
    } info_t;

    // Edge deltas, tile origin offsets and bounding box
    typedef struct packed {
        diff_t [NUM_EDGES-1:0] dx;
        diff_t [NUM_EDGES-1:0] dy;
        ofs_t  [NUM_EDGES-1:0] ofx;
        ofs_t  [NUM_EDGES-1:0] ofy;
        coord_t                minx;
        coord_t                maxx;
        coord_t                miny;
        coord_t                maxy;
        pix_t                  ox;
        pix_t                  oy;
    } setup_t;

    // Edge values at the tile origin plus per-line clip bits
    typedef struct packed {
        edge_t [NUM_EDGES-1:0] e;
        diff_t [NUM_EDGES-1:0] dx;
        diff_t [NUM_EDGES-1:0] dy;
        line_t                 col_ok;
        line_t                 row_ok;
    } edge_set_t;

endpackage

>>> design/ttc_setup.sv
// ----------------------------------------------------------------------------
// ttc_setup
// Edge deltas, origin offsets and vertex bounding box of one triangle.
// ----------------------------------------------------------------------------
module ttc_setup
    import ttc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  tri_t      in_tri,
    input  info_t     in_info,
    output logic      out_valid,
    output setup_t    out_setup,
    output info_t     out_info
);

    logic   valid_reg;
    setup_t setup_reg;
    setup_t setup_next;
    info_t  info_reg;

    function automatic coord_t min3(coord_t a, coord_t b, coord_t c);
        coord_t m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic coord_t max3(coord_t a, coord_t b, coord_t c);
        coord_t m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // Build edge deltas: edge 0 is b->c, edge 1 is c->a, edge 2 is a->b
    always_comb
    begin
        coord_t ux [NUM_EDGES];
        coord_t uy [NUM_EDGES];
        coord_t vx [NUM_EDGES];
        coord_t vy [NUM_EDGES];
        ux[0] = in_tri.bx;  uy[0] = in_tri.by;  vx[0] = in_tri.cx;  vy[0] = in_tri.cy;
        ux[1] = in_tri.cx;  uy[1] = in_tri.cy;  vx[1] = in_tri.ax;  vy[1] = in_tri.ay;
        ux[2] = in_tri.ax;  uy[2] = in_tri.ay;  vx[2] = in_tri.bx;  vy[2] = in_tri.by;
        setup_next.ox = pix_t'(int'(in_info.tile_col) * TILE_SIZE);
        setup_next.oy = pix_t'(int'(in_info.tile_row) * TILE_SIZE);
        for (int k = 0; k < NUM_EDGES; k++)
        begin
            setup_next.dx[k]  = diff_t'(vx[k]) - diff_t'(ux[k]);
            setup_next.dy[k]  = diff_t'(vy[k]) - diff_t'(uy[k]);
            setup_next.ofx[k] = ofs_t'(setup_next.ox) - ofs_t'(ux[k]);
            setup_next.ofy[k] = ofs_t'(setup_next.oy) - ofs_t'(uy[k]);
        end
        setup_next.minx = min3(in_tri.ax, in_tri.bx, in_tri.cx);
        setup_next.maxx = max3(in_tri.ax, in_tri.bx, in_tri.cx);
        setup_next.miny = min3(in_tri.ay, in_tri.by, in_tri.cy);
        setup_next.maxy = max3(in_tri.ay, in_tri.by, in_tri.cy);
    end

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Hold the payload
    always_ff @(posedge clk)
    begin
        setup_reg <= setup_next;
        info_reg  <= in_info;
    end

    assign out_valid = valid_reg;
    assign out_setup = setup_reg;
    assign out_info  = info_reg;

endmodule

>>> design/ttc_edge.sv
// ----------------------------------------------------------------------------
// ttc_edge
// Edge functions at the tile origin, triangle area test and clip bits,
// over two register stages (multiply, then subtract).
// ----------------------------------------------------------------------------
module ttc_edge
    import ttc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  fb_t       fb_width,
    input  fb_t       fb_height,
    input  logic      in_valid,
    input  setup_t    in_setup,
    input  info_t     in_info,
    output logic      out_valid,
    output edge_set_t out_eset,
    output info_t     out_info
);

    // Multiply stage
    logic                  mul_valid_reg;
    prod_t [NUM_EDGES-1:0] prod_x_reg;
    prod_t [NUM_EDGES-1:0] prod_x_next;
    prod_t [NUM_EDGES-1:0] prod_y_reg;
    prod_t [NUM_EDGES-1:0] prod_y_next;
    prod_t                 area_p_reg;
    prod_t                 area_q_reg;
    diff_t [NUM_EDGES-1:0] mul_dx_reg;
    diff_t [NUM_EDGES-1:0] mul_dy_reg;
    line_t                 col_ok_reg;
    line_t                 col_ok_next;
    line_t                 row_ok_reg;
    line_t                 row_ok_next;
    info_t                 mul_info_reg;

    // Subtract stage
    logic                  sub_valid_reg;
    edge_set_t             eset_reg;
    edge_set_t             eset_next;
    info_t                 sub_info_reg;

    // Form edge products and per-column / per-row clip bits
    always_comb
    begin
        pix_t px;
        pix_t py;
        for (int k = 0; k < NUM_EDGES; k++)
        begin
            prod_x_next[k] = in_setup.ofx[k] * in_setup.dy[k];
            prod_y_next[k] = in_setup.ofy[k] * in_setup.dx[k];
        end
        for (int c = 0; c < TILE_SIZE; c++)
        begin
            px = in_setup.ox + pix_t'(c);
            col_ok_next[c] = (cmp_t'(px) >= cmp_t'(in_setup.minx)) &&
                             (cmp_t'(px) <= cmp_t'(in_setup.maxx)) &&
                             (px < fb_width);
        end
        for (int r = 0; r < TILE_SIZE; r++)
        begin
            py = in_setup.oy + pix_t'(r);
            row_ok_next[r] = (cmp_t'(py) >= cmp_t'(in_setup.miny)) &&
                             (cmp_t'(py) <= cmp_t'(in_setup.maxy)) &&
                             (py < fb_height);
        end
    end

    // Combine products; a zero-area triangle clears its column clip bits
    always_comb
    begin
        logic nonzero;
        nonzero = (area_p_reg != area_q_reg);
        for (int k = 0; k < NUM_EDGES; k++)
        begin
            eset_next.e[k] = edge_t'(prod_x_reg[k]) - edge_t'(prod_y_reg[k]);
        end
        eset_next.dx     = mul_dx_reg;
        eset_next.dy     = mul_dy_reg;
        eset_next.col_ok = nonzero ? col_ok_reg : '0;
        eset_next.row_ok = row_ok_reg;
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            sub_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= in_valid;
            sub_valid_reg <= mul_valid_reg;
        end
    end

    // Hold the payload; area = dy1*dx2 - dx1*dy2
    always_ff @(posedge clk)
    begin
        prod_x_reg   <= prod_x_next;
        prod_y_reg   <= prod_y_next;
        area_p_reg   <= in_setup.dy[1] * in_setup.dx[2];
        area_q_reg   <= in_setup.dx[1] * in_setup.dy[2];
        mul_dx_reg   <= in_setup.dx;
        mul_dy_reg   <= in_setup.dy;
        col_ok_reg   <= col_ok_next;
        row_ok_reg   <= row_ok_next;
        mul_info_reg <= in_info;
        eset_reg     <= eset_next;
        sub_info_reg <= mul_info_reg;
    end

    assign out_valid = sub_valid_reg;
    assign out_eset  = eset_reg;
    assign out_info  = sub_info_reg;

endmodule

>>> design/ttc_raster.sv
// ----------------------------------------------------------------------------
// ttc_raster
// Steps the origin edge values across the tile: one stage for the row
// bases, one for every pixel and the coverage mask.
// ----------------------------------------------------------------------------
module ttc_raster
    import ttc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  edge_set_t in_eset,
    input  info_t     in_info,
    output logic      out_valid,
    output mask_t     out_mask,
    output info_t     out_info
);

    // Row stage
    logic                  row_valid_reg;
    edge_t                 base_reg  [NUM_EDGES][TILE_SIZE];
    edge_t                 base_next [NUM_EDGES][TILE_SIZE];
    diff_t [NUM_EDGES-1:0] row_dy_reg;
    line_t                 col_ok_reg;
    line_t                 row_ok_reg;
    info_t                 row_info_reg;

    // Pixel stage
    logic                  pix_valid_reg;
    mask_t                 mask_reg;
    mask_t                 mask_next;
    info_t                 pix_info_reg;

    // Step each edge down the rows: +1 in y subtracts dx
    always_comb
    begin
        for (int k = 0; k < NUM_EDGES; k++)
        begin
            for (int r = 0; r < TILE_SIZE; r++)
            begin
                base_next[k][r] = in_eset.e[k] - edge_t'(in_eset.dx[k]) * edge_t'(r);
            end
        end
    end

    // Step along each row (+1 in x adds dy) and test the three signs
    always_comb
    begin
        edge_t w [NUM_EDGES];
        logic  all_pos;
        logic  all_neg;
        mask_next = '0;
        for (int r = 0; r < TILE_SIZE; r++)
        begin
            for (int c = 0; c < TILE_SIZE; c++)
            begin
                all_pos = 1'b1;
                all_neg = 1'b1;
                for (int k = 0; k < NUM_EDGES; k++)
                begin
                    w[k] = base_reg[k][r] + edge_t'(row_dy_reg[k]) * edge_t'(c);
                    all_pos = all_pos & ~w[k][EDGE_W-1];
                    all_neg = all_neg & (w[k][EDGE_W-1] | (w[k] == '0));
                end
                mask_next[r*TILE_SIZE + c] = col_ok_reg[c] & row_ok_reg[r] &
                                             (all_pos | all_neg);
            end
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= 1'b0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            row_valid_reg <= in_valid;
            pix_valid_reg <= row_valid_reg;
        end
    end

    // Hold the payload
    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        row_dy_reg   <= in_eset.dy;
        col_ok_reg   <= in_eset.col_ok;
        row_ok_reg   <= in_eset.row_ok;
        row_info_reg <= in_info;
        mask_reg     <= mask_next;
        pix_info_reg <= row_info_reg;
    end

    assign out_valid = pix_valid_reg;
    assign out_mask  = mask_reg;
    assign out_info  = pix_info_reg;

endmodule

>>> design/triangle_tile_coverage.sv
// ----------------------------------------------------------------------------
// triangle_tile_coverage
// Coverage mask of one triangle over one 8x8 screen tile, edge-function
// test with either winding, clipped to bounding box and framebuffer.
//
//   Channel  | Handshake          | Payload
//   ---------+--------------------+------------------------------------------
//   item in  | start, busy        | ax_pos..cy_pos, fill_color, tile_col/row
//   item out | done (strobe)      | out_tile_col/row, out_color, coverage
//   config   | cfg_we, cfg_index  | cfg_data (fb_width, fb_height)
//
// One item per cycle; each result passes through the six register stages:
// input, setup, edge multiply, edge subtract, row step, pixel test. busy
// stays low, the pipeline never holds off an item.
// Reset clears the valid bits and loads fb_width 800, fb_height 480.
// The receiver cannot stall, so results leave on done without waiting.
// ----------------------------------------------------------------------------
`include "triangle_tile_coverage_assert.svh"

module triangle_tile_coverage
    import ttc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_we,
    input  cfg_idx_t cfg_index,
    input  fb_t      cfg_data,
    input  logic     start,
    output logic     busy,
    input  coord_t   ax_pos,
    input  coord_t   ay_pos,
    input  coord_t   bx_pos,
    input  coord_t   by_pos,
    input  coord_t   cx_pos,
    input  coord_t   cy_pos,
    input  color_t   fill_color,
    input  tile_t    tile_col,
    input  tile_t    tile_row,
    output logic     done,
    output tile_t    out_tile_col,
    output tile_t    out_tile_row,
    output color_t   out_color,
    output mask_t    coverage
);

    logic      accept;
    fb_t       fb_width_reg;
    fb_t       fb_height_reg;
    logic      in_valid_reg;
    tri_t      tri_reg;
    info_t     info_reg;

    logic      setup_valid;
    setup_t    setup_data;
    info_t     setup_info;
    logic      edge_valid;
    edge_set_t edge_data;
    info_t     edge_info;
    logic      rast_valid;
    mask_t     rast_mask;
    info_t     rast_info;

    // Every cycle takes an item
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Write configuration registers; other indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_width_reg  <= FB_WIDTH_RST;
            fb_height_reg <= FB_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FB_WIDTH:  fb_width_reg  <= cfg_data;
                REG_FB_HEIGHT: fb_height_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Capture the input item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        tri_reg  <= '{ax: ax_pos, ay: ay_pos, bx: bx_pos, by: by_pos,
                      cx: cx_pos, cy: cy_pos};
        info_reg <= '{color: fill_color, tile_col: tile_col, tile_row: tile_row};
    end

    ttc_setup u_setup
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_tri    (tri_reg),
        .in_info   (info_reg),
        .out_valid (setup_valid),
        .out_setup (setup_data),
        .out_info  (setup_info)
    );

    ttc_edge u_edge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fb_width  (fb_width_reg),
        .fb_height (fb_height_reg),
        .in_valid  (setup_valid),
        .in_setup  (setup_data),
        .in_info   (setup_info),
        .out_valid (edge_valid),
        .out_eset  (edge_data),
        .out_info  (edge_info)
    );

    ttc_raster u_raster
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (edge_valid),
        .in_eset   (edge_data),
        .in_info   (edge_info),
        .out_valid (rast_valid),
        .out_mask  (rast_mask),
        .out_info  (rast_info)
    );

    // Drive the result ports
    assign done         = rast_valid;
    assign coverage     = rast_mask;
    assign out_color    = rast_info.color;
    assign out_tile_col = rast_info.tile_col;
    assign out_tile_row = rast_info.tile_row;

    // Every accepted item comes out as a done strobe at the end of the pipeline
    `TTC_ASSERT_DELAY(a_item_latency, clk, rst_n, accept, PIPE_DEPTH, done, "item lost in pipeline")

    // A result strobe traces back to an accepted item and its color
    `TTC_ASSERT_IMPL(a_done_source, clk, rst_n, done, $past(accept, PIPE_DEPTH) && (out_color == $past(fill_color, PIPE_DEPTH)), "result without matching item")

    // Tile index travels with its mask
    `TTC_ASSERT_IMPL(a_tile_echo, clk, rst_n, done, (out_tile_col == $past(tile_col, PIPE_DEPTH)) && (out_tile_row == $past(tile_row, PIPE_DEPTH)), "tile index out of step")

endmodule

>>> tb/triangle_tile_coverage_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_tile_coverage_tb
// Self-checking bench for the triangle tile coverage pipeline. Drives directed
// triangles (full cover, both windings, zero area, clipped and off-screen
// cases), then random triangles built around the chosen tile, across several
// framebuffer sizes and sender idle rates. It predicts each tile mask and
// compares it field by field with the results in order.
// ----------------------------------------------------------------------------
module triangle_tile_coverage_tb
    import ttc_pkg::*;
();

    localparam int       CLK_HALF         = 2;
    localparam int       RESET_CYCLES     = 12;
    localparam int       TILE_MAX         = (1 << TILE_W) - 1;
    localparam int       COORD_MIN        = -(1 << (COORD_W - 1));
    localparam int       COORD_MAX        = (1 << (COORD_W - 1)) - 1;
    localparam int       FB_SIZE_MAX      = 4096;
    localparam int       NUM_PHASES       = 8;
    localparam int       ITEMS_PER_PHASE  = 88;
    localparam int       REPORT_LIMIT     = 10;
    localparam cfg_idx_t FIRST_UNUSED_REG = REG_FB_HEIGHT + cfg_idx_t'(1);

    // One result of the block
    typedef struct packed {
        tile_t  tile_col;
        tile_t  tile_row;
        color_t color;
        mask_t  mask;
    } tile_result_t;

    // ------------------------------------------------------------------------
    // Expected tile masks, in order of acceptance
    // ------------------------------------------------------------------------
    class tile_mask_checker;
        fb_t          fb_width;
        fb_t          fb_height;
        tile_result_t expected_tiles[$];
        int           tiles_checked;
        int           zero_area;
        int           full_tiles;
        int           empty_tiles;
        int           mismatches;

        function new();
            fb_width      = FB_WIDTH_RST;
            fb_height     = FB_HEIGHT_RST;
            tiles_checked = 0;
            zero_area     = 0;
            full_tiles    = 0;
            empty_tiles   = 0;
            mismatches    = 0;
        endfunction

        // Writes to any other index are dropped
        function void write_reg(cfg_idx_t idx, fb_t data);
            if (idx == REG_FB_WIDTH)
                fb_width = data;
            else if (idx == REG_FB_HEIGHT)
                fb_height = data;
        endfunction

        // Signed side of point p against the directed line u -> v
        function longint side_of(longint ux, longint uy, longint vx, longint vy,
                                 longint px, longint py);
            return (px - ux) * (vy - uy) - (py - uy) * (vx - ux);
        endfunction

        function mask_t tile_mask(tri_t t, info_t inf);
            longint ax, ay, bx, by, cx, cy;
            longint minx, maxx, miny, maxy;
            longint ox, oy, px, py, w0, w1, w2;
            mask_t  m;
            ax = longint'($signed(t.ax));
            ay = longint'($signed(t.ay));
            bx = longint'($signed(t.bx));
            by = longint'($signed(t.by));
            cx = longint'($signed(t.cx));
            cy = longint'($signed(t.cy));
            minx = ax;
            maxx = ax;
            miny = ay;
            maxy = ay;
            if (bx < minx) minx = bx;
            if (cx < minx) minx = cx;
            if (bx > maxx) maxx = bx;
            if (cx > maxx) maxx = cx;
            if (by < miny) miny = by;
            if (cy < miny) miny = cy;
            if (by > maxy) maxy = by;
            if (cy > maxy) maxy = cy;
            m = '0;
            // A degenerate triangle covers nothing
            if (side_of(ax, ay, bx, by, cx, cy) == 0)
            begin
                zero_area++;
                return m;
            end
            ox = longint'(inf.tile_col) * TILE_SIZE;
            oy = longint'(inf.tile_row) * TILE_SIZE;
            for (int r = 0; r < TILE_SIZE; r++)
            begin
                py = oy + r;
                if (py < miny || py > maxy || py >= longint'(fb_height))
                    continue;
                for (int c = 0; c < TILE_SIZE; c++)
                begin
                    px = ox + c;
                    if (px < minx || px > maxx || px >= longint'(fb_width))
                        continue;
                    w0 = side_of(bx, by, cx, cy, px, py);
                    w1 = side_of(cx, cy, ax, ay, px, py);
                    w2 = side_of(ax, ay, bx, by, px, py);
                    // Either winding, edges inclusive
                    if ((w0 >= 0 && w1 >= 0 && w2 >= 0) ||
                        (w0 <= 0 && w1 <= 0 && w2 <= 0))
                        m[r * TILE_SIZE + c] = 1'b1;
                end
            end
            return m;
        endfunction

        function void note_item(tri_t t, info_t inf);
            tile_result_t exp_tile;
            exp_tile.tile_col = inf.tile_col;
            exp_tile.tile_row = inf.tile_row;
            exp_tile.color    = inf.color;
            exp_tile.mask     = tile_mask(t, inf);
            if (exp_tile.mask == '1)
                full_tiles++;
            else if (exp_tile.mask == '0)
                empty_tiles++;
            expected_tiles.push_back(exp_tile);
        endfunction

        function void report(string what, logic [MASK_W-1:0] exp_val,
                             logic [MASK_W-1:0] got_val);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("[%0t] MISMATCH %s: expected %h, got %h",
                         $realtime, what, exp_val, got_val);
        endfunction

        function void check_result(tile_result_t got);
            tile_result_t exp_tile;
            if (expected_tiles.size() == 0)
            begin
                report("result with no item pending", '0, got.mask);
                return;
            end
            exp_tile = expected_tiles.pop_front();
            tiles_checked++;
            if (got.tile_col != exp_tile.tile_col)
                report("out_tile_col", exp_tile.tile_col, got.tile_col);
            if (got.tile_row != exp_tile.tile_row)
                report("out_tile_row", exp_tile.tile_row, got.tile_row);
            if (got.color != exp_tile.color)
                report("out_color", exp_tile.color, got.color);
            if (got.mask != exp_tile.mask)
                report("coverage", exp_tile.mask, got.mask);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------------
    logic     clk        = 1'b0;
    logic     rst_n      = 1'b0;
    logic     cfg_we     = 1'b0;
    cfg_idx_t cfg_index  = '0;
    fb_t      cfg_data   = '0;
    logic     start      = 1'b0;
    logic     busy;
    coord_t   ax_pos     = '0;
    coord_t   ay_pos     = '0;
    coord_t   bx_pos     = '0;
    coord_t   by_pos     = '0;
    coord_t   cx_pos     = '0;
    coord_t   cy_pos     = '0;
    color_t   fill_color = '0;
    tile_t    tile_col   = '0;
    tile_t    tile_row   = '0;
    logic     done;
    tile_t    out_tile_col;
    tile_t    out_tile_row;
    color_t   out_color;
    mask_t    coverage;

    tile_mask_checker tiles = new();

    int idle_pct = 0;
    int cur_w    = FB_WIDTH_RST;
    int cur_h    = FB_HEIGHT_RST;
    int settings = 1;

    triangle_tile_coverage u_dut (.*);

    // Clock
    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    // Hard stop if the pipeline hangs
    initial
    begin
        #(2_000_000);
        $display("triangle_tile_coverage verification failed");
        $finish;
    end

    // Watch register writes, accepted items and result strobes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                tiles.write_reg(cfg_index, cfg_data);
            if (start && !busy)
                tiles.note_item('{ax: ax_pos, ay: ay_pos, bx: bx_pos, by: by_pos,
                                  cx: cx_pos, cy: cy_pos},
                                '{color: fill_color, tile_col: tile_col,
                                  tile_row: tile_row});
            if (done)
                tiles.check_result('{tile_col: out_tile_col, tile_row: out_tile_row,
                                     color: out_color, mask: coverage});
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    function automatic tri_t mk_tri(int ax, int ay, int bx, int by, int cx, int cy);
        return '{ax: coord_t'(ax), ay: coord_t'(ay), bx: coord_t'(bx),
                 by: coord_t'(by), cx: coord_t'(cx), cy: coord_t'(cy)};
    endfunction

    function automatic info_t mk_info(int color, int col, int row);
        return '{color: color_t'(color), tile_col: tile_t'(col), tile_row: tile_t'(row)};
    endfunction

    // Coordinate within spread of center, held to the 13-bit range
    function automatic coord_t near(int center, int spread);
        int v;
        v = center + int'($urandom_range(2 * spread)) - spread;
        if (v < COORD_MIN)
            v = COORD_MIN;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return coord_t'(v);
    endfunction

    // Present one item, hold until accepted, then idle at random
    task automatic send_tri(input tri_t t, input info_t inf);
        ax_pos     <= t.ax;
        ay_pos     <= t.ay;
        bx_pos     <= t.bx;
        by_pos     <= t.by;
        cx_pos     <= t.cx;
        cy_pos     <= t.cy;
        fill_color <= inf.color;
        tile_col   <= inf.tile_col;
        tile_row   <= inf.tile_row;
        start      <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        while (int'($urandom_range(99)) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Drop start and wait for every pending tile to come back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (tiles.expected_tiles.size() != 0)
            @(posedge clk);
    endtask

    // Present one register write; the caller drops cfg_we after the last one
    task automatic write_reg(input cfg_idx_t idx, input fb_t data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Set framebuffer size, plus a write to an unused index that must be dropped
    task automatic set_framebuffer(input int w, input int h);
        write_reg(REG_FB_WIDTH, fb_t'(w));
        write_reg(REG_FB_HEIGHT, fb_t'(h));
        write_reg(cfg_idx_t'($urandom_range(FIRST_UNUSED_REG, {CFG_IDX_W{1'b1}})),
                  fb_t'($urandom));
        cfg_we <= 1'b0;
        cur_w = w;
        cur_h = h;
        settings++;
        @(posedge clk);
    endtask

    // Random triangle, mostly built around a tile that the framebuffer keeps
    task automatic send_random_tri();
        int     col_hi, row_hi, col, row, ox, oy, kind;
        tri_t   t;
        col_hi = (cur_w == 0) ? TILE_MAX : (cur_w - 1) / TILE_SIZE;
        row_hi = (cur_h == 0) ? TILE_MAX : (cur_h - 1) / TILE_SIZE;
        if (col_hi > TILE_MAX) col_hi = TILE_MAX;
        if (row_hi > TILE_MAX) row_hi = TILE_MAX;
        if ($urandom_range(99) < 75)
        begin
            col = $urandom_range(col_hi);
            row = $urandom_range(row_hi);
        end
        else
        begin
            col = $urandom_range(TILE_MAX);
            row = $urandom_range(TILE_MAX);
        end
        ox   = col * TILE_SIZE + TILE_SIZE / 2;
        oy   = row * TILE_SIZE + TILE_SIZE / 2;
        kind = $urandom_range(99);
        if (kind < 60)
            t = '{ax: near(ox, 24), ay: near(oy, 24), bx: near(ox, 24),
                  by: near(oy, 24), cx: near(ox, 24), cy: near(oy, 24)};
        else if (kind < 80)
            t = '{ax: near(ox, 400), ay: near(oy, 400), bx: near(ox, 400),
                  by: near(oy, 400), cx: near(ox, 400), cy: near(oy, 400)};
        else if (kind < 90)
            t = '{ax: coord_t'($urandom), ay: coord_t'($urandom),
                  bx: coord_t'($urandom), by: coord_t'($urandom),
                  cx: coord_t'($urandom), cy: coord_t'($urandom)};
        else
        begin
            // Degenerate: repeated vertex or third point on the line
            t.ax = near(ox, 16);
            t.ay = near(oy, 16);
            t.bx = near(ox, 16);
            t.by = near(oy, 16);
            case ($urandom_range(2))
                0:
                begin
                    t.cx = t.ax;
                    t.cy = t.ay;
                end
                1:
                begin
                    t.cx = t.bx;
                    t.cy = t.by;
                end
                default:
                begin
                    t.cx = near(2 * int'(t.bx) - int'(t.ax), 0);
                    t.cy = near(2 * int'(t.by) - int'(t.ay), 0);
                end
            endcase
        end
        send_tri(t, mk_info($urandom, col, row));
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int idle_tab[3] = '{0, 65, 14};
        int w_tab[NUM_PHASES] = '{800, 1, 0, 333, 4096, 8191, 640, 0};
        int h_tab[NUM_PHASES] = '{480, 1, 200, 0, 4096, 8191, 8, 0};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed triangles under the reset size 800 x 480
        send_tri(mk_tri(-4096, -4096, 4095, -4096, -4096, 4095), mk_info(0, 0, 0));
        send_tri(mk_tri(-4096, -4096, -4096, 4095, 4095, -4096),
                 mk_info('hFFFFFF, 1, 1));
        send_tri(mk_tri(10, 10, 10, 10, 10, 10), mk_info('h123456, 1, 1));
        send_tri(mk_tri(0, 0, 4, 4, 8, 8), mk_info('h00FF00, 0, 0));
        send_tri(mk_tri(-4096, -4096, -4096, -4096, -4096, -4096), mk_info(1, 0, 0));
        send_tri(mk_tri(4095, 4095, 4095, 4095, 4095, 4095),
                 mk_info('hFF0000, TILE_MAX, TILE_MAX));
        send_tri(mk_tri(1, 1, 6, 1, 1, 6), mk_info('h0000FF, 0, 0));
        send_tri(mk_tri(1, 1, 1, 6, 6, 1), mk_info('h0000FF, 0, 0));
        send_tri(mk_tri(8, 8, 15, 15, 8, 15), mk_info('h808080, 1, 1));
        send_tri(mk_tri(-4096, -4096, 4095, -4096, -4096, 4095),
                 mk_info('h7F7F7F, TILE_MAX, TILE_MAX));
        send_tri(mk_tri(0, 0, 5, 0, 0, 5), mk_info('h010203, 3, 3));
        send_tri(mk_tri(-4096, -4096, 4095, 4095, -4096, 4095), mk_info('h111111, 99, 59));
        send_tri(mk_tri(-4096, -4096, 4095, 4095, 4095, -4096), mk_info('h222222, 100, 59));
        send_tri(mk_tri(-4096, -4096, 4095, 4095, 4095, -4096), mk_info('h333333, 99, 60));
        send_tri(mk_tri(-100, -50, 300, -20, 20, 200), mk_info('h444444, 2, 2));
        send_tri(mk_tri(0, 0, 63, 1, 0, 1), mk_info('h555555, 3, 0));
        send_tri(mk_tri(-4096, 4095, 4095, 4095, 0, -4096),
                 mk_info('hAAAAAA, TILE_MAX, 0));
        send_tri(mk_tri(4095, -4096, 4095, 4095, -4096, 0),
                 mk_info('h555555, 0, TILE_MAX));
        send_tri(mk_tri(3, -2, 9, 5, -2, 7), mk_info('hC0FFEE, 0, 0));

        // Random triangles over several sizes and idle rates
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            if (p == NUM_PHASES - 1)
                set_framebuffer($urandom_range(1, FB_SIZE_MAX),
                                $urandom_range(1, FB_SIZE_MAX));
            else
                set_framebuffer(w_tab[p], h_tab[p]);
            idle_pct = idle_tab[p % 3];
            repeat (ITEMS_PER_PHASE)
                send_random_tri();
        end

        // Let the pipeline empty, then allow for stray strobes
        drain();
        repeat (PIPE_DEPTH + 4) @(posedge clk);

        if (tiles.expected_tiles.size() != 0)
        begin
            $display("MISMATCH: %0d tiles never returned", tiles.expected_tiles.size());
            tiles.mismatches += tiles.expected_tiles.size();
        end

        $display("Summary: %0d tiles, %0d framebuffer sizes",
                 tiles.tiles_checked, settings);
        $display("Summary: %0d zero-area, %0d full, %0d empty, %0d mismatches",
                 tiles.zero_area, tiles.full_tiles, tiles.empty_tiles,
                 tiles.mismatches);
        if (tiles.mismatches == 0)
            $display("triangle_tile_coverage verification clean");
        else
            $display("triangle_tile_coverage verification failed");
        $finish;
    end

endmodule
